[hw/rtl/midi_message_assembler_unit_macros.svh]
// ----------------------------------------------------------------------------
// midi message assembler assertion macros
// property wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_ASSEMBLER_UNIT_MACROS_SVH
`define MIDI_MESSAGE_ASSEMBLER_UNIT_MACROS_SVH

`ifndef SYNTH

`define MMA_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define MMA_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define MMA_ASSERT_IMP(lbl, clk, rst_n, pre, post)

`define MMA_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

[hw/rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// shared constants, types and decode helpers of the midi message assembler
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int SYSEX_LIMIT = 63;
    localparam int ADDR_W      = $clog2(SYSEX_LIMIT);
    localparam int CNT_W       = $clog2(SYSEX_LIMIT + 1);

    localparam logic [CNT_W-1:0] SYSEX_LIMIT_C = CNT_W'(SYSEX_LIMIT);

    typedef logic [7:0] midi_byte_t;

    localparam midi_byte_t ST_SYSEX   = 8'hF0;
    localparam midi_byte_t ST_MTC     = 8'hF1;
    localparam midi_byte_t ST_SONGPOS = 8'hF2;
    localparam midi_byte_t ST_SONGSEL = 8'hF3;
    localparam midi_byte_t ST_UNDEF   = 8'hF4;
    localparam midi_byte_t ST_EOX     = 8'hF7;
    localparam midi_byte_t RT_FIRST   = 8'hF8;
    localparam midi_byte_t RT_LAST    = 8'hFF;

    localparam logic [3:0] HI_PROG  = 4'hC;
    localparam logic [3:0] HI_PRESS = 4'hD;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FL_RD,
        S_FL_WR,
        S_FL_END
    } mma_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        midi_byte_t        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mma_mem_req_t;

    function automatic logic [1:0] msg_len(input midi_byte_t s);
        logic [1:0] n;
        if (s inside {[RT_FIRST:RT_LAST]})
            n = 2'd1;
        else if (s inside {ST_MTC, ST_SONGSEL})
            n = 2'd2;
        else if (s == ST_SONGPOS)
            n = 2'd3;
        else if (s inside {[ST_UNDEF:ST_EOX]})
            n = 2'd1;
        else if (s[7:4] inside {HI_PROG, HI_PRESS})
            n = 2'd2;
        else
            n = 2'd3;
        return n;
    endfunction

endpackage

[hw/rtl/mma_sysex_store.sv]
// ----------------------------------------------------------------------------
// mma_sysex_store
// sysex byte buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module mma_sysex_store
    import mma_pkg::*;
(
    input  logic         clk,
    input  mma_mem_req_t mem_req,
    output midi_byte_t   rd_data
);

    midi_byte_t mem [SYSEX_LIMIT];
    midi_byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/midi_message_assembler_unit.sv]
// ----------------------------------------------------------------------------
// midi_message_assembler_unit
// assembles raw midi bytes into short messages and buffered sysex runs
// ----------------------------------------------------------------------------
// input channel: data_valid / data_ready with data_byte, one raw midi byte
// per transaction. output channel: msg_valid / msg_ready with msg_kind,
// msg_length, byte0..byte2 and last_in_run.
// a byte is accepted in S_IDLE, then decoded and state updated in S_EXEC.
// a completed short message or real-time byte appears on the output
// register the cycle after decode.
// on f7 closing a sysex the buffer is walked through the store's single
// read port: S_FL_RD reads each buffered byte and S_FL_WR places it on
// the output, then S_FL_END emits the f7.
// data_ready is high only while the block is idle; a finished result may
// wait in the output register while the next byte is accepted.
// if the receiver stalls, decode or flush holds until the output register
// is free; no result is lost.
// reset clears running status, partial message and sysex state; the
// store needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
`include "midi_message_assembler_unit_macros.svh"

module midi_message_assembler_unit
    import mma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_ready,
    input  midi_byte_t data_byte,
    output logic       msg_valid,
    input  logic       msg_ready,
    output logic       msg_kind,
    output logic [1:0] msg_length,
    output midi_byte_t byte0,
    output midi_byte_t byte1,
    output midi_byte_t byte2,
    output logic       last_in_run
);

    mma_state_t state_reg, state_next;

    midi_byte_t        byte_reg, byte_next;
    midi_byte_t        run_reg, run_next;
    midi_byte_t        part_reg [3];
    midi_byte_t        part_next [3];
    logic [1:0]        have_reg, have_next;
    logic [1:0]        want_reg, want_next;
    logic              sysex_reg, sysex_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [1:0]        len_reg, len_next;
    midi_byte_t        b0_reg, b0_next;
    midi_byte_t        b1_reg, b1_next;
    midi_byte_t        b2_reg, b2_next;
    logic              last_reg, last_next;

    mma_mem_req_t mem_req;
    midi_byte_t   sx_rd_data;

    logic slot_free;
    logic flush_last;

    // decode results for the byte in byte_reg
    logic              ex_emit;
    logic [1:0]        ex_len;
    midi_byte_t        ex_b0, ex_b1, ex_b2;
    midi_byte_t        ex_run;
    midi_byte_t        ex_part [3];
    logic [1:0]        ex_have, ex_want;
    logic              ex_sysex;
    logic [CNT_W-1:0]  ex_cnt;
    logic              ex_flush;
    logic              ex_we;
    logic [ADDR_W-1:0] ex_waddr;
    logic              ex_go;

    logic [1:0] dh, dw, dn, dsel;
    logic       dok;

    mma_sysex_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (sx_rd_data)
    );

    assign slot_free  = !out_valid_reg || msg_ready;
    assign flush_last = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    always_comb
    begin
        ex_emit  = 1'b0;
        ex_len   = 2'd1;
        ex_b0    = byte_reg;
        ex_b1    = '0;
        ex_b2    = '0;
        ex_run   = run_reg;
        ex_part  = part_reg;
        ex_have  = have_reg;
        ex_want  = want_reg;
        ex_sysex = sysex_reg;
        ex_cnt   = cnt_reg;
        ex_flush = 1'b0;
        ex_we    = 1'b0;
        ex_waddr = cnt_reg[ADDR_W-1:0];
        dh       = have_reg;
        dw       = want_reg;
        dn       = have_reg;
        dsel     = have_reg;
        dok      = 1'b1;

        if (byte_reg >= RT_FIRST)
        begin
            ex_emit = 1'b1;
        end
        else if (sysex_reg && byte_reg == ST_EOX)
        begin
            ex_flush = 1'b1;
        end
        else if (sysex_reg && !byte_reg[7])
        begin
            if (cnt_reg < SYSEX_LIMIT_C)
            begin
                ex_we  = 1'b1;
                ex_cnt = cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            // leaving or not in a sysex
            ex_sysex = 1'b0;
            ex_cnt   = '0;
            if (byte_reg == ST_SYSEX)
            begin
                ex_sysex = 1'b1;
                ex_we    = 1'b1;
                ex_waddr = '0;
                ex_cnt   = CNT_W'(1);
                ex_run   = '0;
            end
            else if (byte_reg[7])
            begin
                ex_run     = (byte_reg < ST_SYSEX) ? byte_reg : 8'h00;
                ex_part[0] = byte_reg;
                ex_want    = msg_len(byte_reg);
                if (msg_len(byte_reg) == 2'd1)
                begin
                    ex_emit = 1'b1;
                    ex_have = 2'd0;
                end
                else
                begin
                    ex_have = 2'd1;
                end
            end
            else
            begin
                if (have_reg == 2'd0)
                begin
                    if (run_reg == 8'h00)
                    begin
                        dok = 1'b0;
                    end
                    else
                    begin
                        ex_part[0] = run_reg;
                        dh         = 2'd1;
                        dw         = msg_len(run_reg);
                    end
                end
                if (dok)
                begin
                    ex_want       = dw;
                    dsel          = (dh == 2'd3) ? 2'd2 : dh;
                    ex_part[dsel] = byte_reg;
                    dn            = dh + 2'd1;
                    if (dn == dw || dn == 2'd0)
                    begin
                        ex_emit = 1'b1;
                        ex_len  = dw;
                        ex_b0   = ex_part[0];
                        ex_b1   = (dw > 2'd1) ? ex_part[1] : 8'h00;
                        ex_b2   = (dw > 2'd2) ? ex_part[2] : 8'h00;
                        ex_have = (run_reg != 8'h00) ? 2'd1 : 2'd0;
                    end
                    else
                    begin
                        ex_have = dn;
                    end
                end
            end
        end
    end

    assign ex_go = !ex_emit || slot_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (data_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ex_go)
                begin
                    if (ex_flush)
                        state_next = (cnt_reg != '0) ? S_FL_RD : S_FL_END;
                    else
                        state_next = S_IDLE;
                end
            end
            S_FL_RD:
            begin
                state_next = S_FL_WR;
            end
            S_FL_WR:
            begin
                if (slot_free)
                begin
                    state_next = flush_last ? S_FL_END : S_FL_RD;
                end
            end
            S_FL_END:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        data_ready     = 1'b0;
        byte_next      = byte_reg;
        run_next       = run_reg;
        part_next      = part_reg;
        have_next      = have_reg;
        want_next      = want_reg;
        sysex_next     = sysex_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        mem_req        = '0;
        out_valid_next = out_valid_reg && !msg_ready;
        kind_next      = kind_reg;
        len_next       = len_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                data_ready = 1'b1;
                if (data_valid)
                begin
                    byte_next = data_byte;
                end
            end
            S_EXEC:
            begin
                if (ex_go)
                begin
                    run_next      = ex_run;
                    part_next     = ex_part;
                    have_next     = ex_have;
                    want_next     = ex_want;
                    sysex_next    = ex_sysex;
                    cnt_next      = ex_cnt;
                    idx_next      = '0;
                    mem_req.we    = ex_we;
                    mem_req.waddr = ex_waddr;
                    mem_req.wdata = byte_reg;
                    if (ex_emit)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_SHORT;
                        len_next       = ex_len;
                        b0_next        = ex_b0;
                        b1_next        = ex_b1;
                        b2_next        = ex_b2;
                        last_next      = 1'b1;
                    end
                end
            end
            S_FL_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = idx_reg;
            end
            S_FL_WR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_SYSEX;
                    len_next       = 2'd1;
                    b0_next        = sx_rd_data;
                    b1_next        = 8'h00;
                    b2_next        = 8'h00;
                    last_next      = 1'b0;
                    idx_next       = idx_reg + ADDR_W'(1);
                end
            end
            S_FL_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_SYSEX;
                    len_next       = 2'd1;
                    b0_next        = ST_EOX;
                    b1_next        = 8'h00;
                    b2_next        = 8'h00;
                    last_next      = 1'b1;
                    cnt_next       = '0;
                    sysex_next     = 1'b0;
                end
            end
            default:
            begin
                data_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= '0;
            part_reg[0]   <= '0;
            part_reg[1]   <= '0;
            part_reg[2]   <= '0;
            have_reg      <= '0;
            want_reg      <= '0;
            sysex_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            part_reg      <= part_next;
            have_reg      <= have_next;
            want_reg      <= want_next;
            sysex_reg     <= sysex_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        len_reg  <= len_next;
        b0_reg   <= b0_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        last_reg <= last_next;
    end

    assign msg_valid   = out_valid_reg;
    assign msg_kind    = kind_reg;
    assign msg_length  = len_reg;
    assign byte0       = b0_reg;
    assign byte1       = b1_reg;
    assign byte2       = b2_reg;
    assign last_in_run = last_reg;

    `MMA_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= SYSEX_LIMIT_C)
    `MMA_ASSERT_IMP(a_sysex_cnt, clk, rst_n, 1'b1, sysex_reg == (cnt_reg != '0))
    `MMA_ASSERT_IMP(a_flush_idx, clk, rst_n, state_reg == S_FL_RD || state_reg == S_FL_WR,
        CNT_W'(idx_reg) < cnt_reg)
    `MMA_ASSERT_NXT(a_flush_end, clk, rst_n, state_reg == S_FL_END && slot_free,
        state_reg == S_IDLE && out_valid_reg && last_reg && !sysex_reg)

endmodule
